>>> rtl/websocket_frame_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define WSDF_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("wsdf: same-cycle check failed");

// next-cycle implication
`define WSDF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("wsdf: next-cycle check failed");

`endif

>>> rtl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// types and constants shared by the websocket frame deframer
// ----------------------------------------------------------------------------
package wsdf_pkg;

	typedef enum logic [3:0] {
		ERR_NONE       = 4'd0,
		ERR_LEN_MSB    = 4'd1,
		ERR_NONMIN16   = 4'd2,
		ERR_NONMIN64   = 4'd3,
		ERR_LIMIT      = 4'd4,
		ERR_CTRL_FRAG  = 4'd5,
		ERR_CTRL_LONG  = 4'd6,
		ERR_UNMASKED   = 4'd7,
		ERR_RSV        = 4'd8,
		ERR_OPCODE     = 4'd9
	} err_code_t;

	localparam logic [6:0]  LEN_CODE_EXT16 = 7'd126;
	localparam logic [63:0] CTRL_MAX_LEN   = 64'd125;
	localparam logic [63:0] EXT16_MIN_LEN  = 64'd126;
	localparam logic [31:0] LIMIT_RESET    = 32'd65536;
	localparam logic [3:0]  EXT16_BYTES    = 4'd2;
	localparam logic [3:0]  EXT64_BYTES    = 4'd8;
	localparam logic [3:0]  MASK_BYTES     = 4'd4;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        payload_valid;
		logic        header_done;
		logic [3:0]  opcode;
		logic [3:0]  message_type;
		logic        fin_flag;
		logic [31:0] payload_length;
		logic        frame_last;
		logic        error_flag;
		err_code_t   error_code;
	} res_t;

endpackage

>>> rtl/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser
// header parser, checks and payload unmasking, one byte per request
// ----------------------------------------------------------------------------
module wsdf_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	input  logic              cfg_write_en,
	input  logic [31:0]       cfg_write_data,
	output wsdf_pkg::res_t    res
);

	`include "websocket_frame_deframer_unit_assert.svh"

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_MASK  = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		LEN7  = 2'd0,
		LEN16 = 2'd1,
		LEN64 = 2'd2
	} len_kind_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  byte_idx_q, byte_idx_d;
	logic [7:0]  hdr0_q, hdr0_d;
	logic [63:0] len_acc_q, len_acc_d;
	logic [31:0] mask_key_q, mask_key_d;
	logic [31:0] remaining_q, remaining_d;
	logic [1:0]  mask_pos_q, mask_pos_d;
	logic [3:0]  msg_type_q, msg_type_d;
	logic        err_q, err_d;
	logic        mask_bit_q, mask_bit_d;
	logic [31:0] limit_q;

	logic [63:0]         ext_len;
	logic [63:0]         cand_len;
	logic                cand_mask;
	len_kind_t           cand_kind;
	wsdf_pkg::err_code_t chk_code;
	wsdf_pkg::err_code_t code;
	logic [3:0]          idx_inc;
	logic                finish;
	logic [7:0]          key_byte;
	logic [7:0]          obyte;
	logic                valid;
	logic                hdone;
	logic                last;

	function automatic wsdf_pkg::err_code_t check_hdr(
		input len_kind_t   kind,
		input logic [63:0] len,
		input logic [7:0]  hdr,
		input logic        mbit,
		input logic [31:0] limit
	);
		logic ctrl;
		logic over;
		logic [3:0] op;
		wsdf_pkg::err_code_t c;
		op   = hdr[3:0];
		ctrl = op[3];
		over = (len[63:32] != 32'd0) || (len[31:0] > limit);
		priority if (kind == LEN64 && len[63])
			c = wsdf_pkg::ERR_LEN_MSB;
		else if (kind == LEN16 && len < wsdf_pkg::EXT16_MIN_LEN)
			c = wsdf_pkg::ERR_NONMIN16;
		else if (kind == LEN64 && len[63:16] == 48'd0)
			c = wsdf_pkg::ERR_NONMIN64;
		else if (over)
			c = wsdf_pkg::ERR_LIMIT;
		else if (ctrl && !hdr[7])
			c = wsdf_pkg::ERR_CTRL_FRAG;
		else if (ctrl && len > wsdf_pkg::CTRL_MAX_LEN)
			c = wsdf_pkg::ERR_CTRL_LONG;
		else if (!mbit)
			c = wsdf_pkg::ERR_UNMASKED;
		else if (hdr[6:4] != 3'd0)
			c = wsdf_pkg::ERR_RSV;
		else if ((op >= 4'd3 && op <= 4'd7) || op >= 4'd11)
			c = wsdf_pkg::ERR_OPCODE;
		else
			c = wsdf_pkg::ERR_NONE;
		return c;
	endfunction

	// length and mask bit as they stand once this byte is taken
	always_comb begin
		ext_len   = {len_acc_q[55:0], data_byte};
		cand_len  = (phase_q == PH_HDR1) ? {57'd0, data_byte[6:0]} : ext_len;
		cand_mask = (phase_q == PH_HDR1) ? data_byte[7] : mask_bit_q;
		unique case (phase_q)
			PH_HDR1:  cand_kind = LEN7;
			PH_EXT16: cand_kind = LEN16;
			default:  cand_kind = LEN64;
		endcase
		chk_code = check_hdr(cand_kind, cand_len, hdr0_q, cand_mask, limit_q);
	end

	always_comb begin
		unique case (mask_pos_q)
			2'd0: key_byte = mask_key_q[31:24];
			2'd1: key_byte = mask_key_q[23:16];
			2'd2: key_byte = mask_key_q[15:8];
			2'd3: key_byte = mask_key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		byte_idx_d  = byte_idx_q;
		hdr0_d      = hdr0_q;
		len_acc_d   = len_acc_q;
		mask_key_d  = mask_key_q;
		remaining_d = remaining_q;
		mask_pos_d  = mask_pos_q;
		msg_type_d  = msg_type_q;
		err_d       = err_q;
		mask_bit_d  = mask_bit_q;
		code        = wsdf_pkg::ERR_NONE;
		obyte       = 8'd0;
		valid       = 1'b0;
		hdone       = 1'b0;
		last        = 1'b0;
		finish      = 1'b0;
		idx_inc     = byte_idx_q + 4'd1;
		if (restart) begin
			phase_d     = PH_HDR0;
			byte_idx_d  = 4'd0;
			hdr0_d      = 8'd0;
			len_acc_d   = 64'd0;
			mask_key_d  = 32'd0;
			remaining_d = 32'd0;
			mask_pos_d  = 2'd0;
			msg_type_d  = 4'd0;
			err_d       = 1'b0;
			mask_bit_d  = 1'b0;
		end else if (!err_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					hdr0_d     = data_byte;
					len_acc_d  = 64'd0;
					mask_key_d = 32'd0;
					phase_d    = PH_HDR1;
				end
				PH_HDR1: begin
					mask_bit_d = data_byte[7];
					len_acc_d  = 64'd0;
					byte_idx_d = 4'd0;
					if (data_byte[6:0] < wsdf_pkg::LEN_CODE_EXT16) begin
						len_acc_d = cand_len;
						finish    = 1'b1;
					end else if (data_byte[6:0] == wsdf_pkg::LEN_CODE_EXT16) begin
						phase_d = PH_EXT16;
					end else begin
						phase_d = PH_EXT64;
					end
				end
				PH_EXT16, PH_EXT64: begin
					len_acc_d  = ext_len;
					byte_idx_d = idx_inc;
					if (phase_q == PH_EXT16 && idx_inc >= wsdf_pkg::EXT16_BYTES)
						finish = 1'b1;
					else if (phase_q == PH_EXT64 && idx_inc >= wsdf_pkg::EXT64_BYTES)
						finish = 1'b1;
				end
				PH_MASK: begin
					mask_key_d = {mask_key_q[23:0], data_byte};
					byte_idx_d = idx_inc;
					if (idx_inc >= wsdf_pkg::MASK_BYTES) begin
						hdone      = 1'b1;
						byte_idx_d = 4'd0;
						mask_pos_d = 2'd0;
						// continuation keeps the earlier message type
						if (hdr0_q[3:0] != 4'd0)
							msg_type_d = hdr0_q[3:0];
						if (remaining_q == 32'd0) begin
							last    = 1'b1;
							phase_d = PH_HDR0;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					obyte       = data_byte ^ key_byte;
					valid       = 1'b1;
					mask_pos_d  = mask_pos_q + 2'd1;
					remaining_d = remaining_q - 32'd1;
					if (remaining_q == 32'd1) begin
						last    = 1'b1;
						phase_d = PH_HDR0;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
			if (finish) begin
				if (chk_code != wsdf_pkg::ERR_NONE) begin
					err_d = 1'b1;
					code  = chk_code;
				end else begin
					remaining_d = cand_len[31:0];
					byte_idx_d  = 4'd0;
					mask_pos_d  = 2'd0;
					phase_d     = PH_MASK;
				end
			end
		end
	end

	always_comb begin
		res.out_byte       = obyte;
		res.payload_valid  = valid;
		res.header_done    = hdone;
		res.opcode         = hdr0_d[3:0];
		res.message_type   = msg_type_d;
		res.fin_flag       = hdr0_d[7];
		res.payload_length = len_acc_d[31:0];
		res.frame_last     = last;
		res.error_flag     = err_d;
		res.error_code     = code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			byte_idx_q  <= 4'd0;
			hdr0_q      <= 8'd0;
			len_acc_q   <= 64'd0;
			mask_key_q  <= 32'd0;
			remaining_q <= 32'd0;
			mask_pos_q  <= 2'd0;
			msg_type_q  <= 4'd0;
			err_q       <= 1'b0;
			mask_bit_q  <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			byte_idx_q  <= byte_idx_d;
			hdr0_q      <= hdr0_d;
			len_acc_q   <= len_acc_d;
			mask_key_q  <= mask_key_d;
			remaining_q <= remaining_d;
			mask_pos_q  <= mask_pos_d;
			msg_type_q  <= msg_type_d;
			err_q       <= err_d;
			mask_bit_q  <= mask_bit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= wsdf_pkg::LIMIT_RESET;
		end else if (cfg_write_en) begin
			limit_q <= cfg_write_data;
		end
	end

	`WSDF_ASSERT_IMPL(a_data_emits, clk, arst_n, accept && !restart && !err_q && phase_q == PH_DATA, res.payload_valid)
	`WSDF_ASSERT_IMPL(a_hdone_in_mask, clk, arst_n, res.header_done, phase_q == PH_MASK && !err_q)
	`WSDF_ASSERT_NEXT(a_err_freeze, clk, arst_n, accept && !restart && err_q, err_q && $stable(hdr0_q) && $stable(len_acc_q))

endmodule

>>> rtl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit: client frame header parse, checks, unmasking
// result: registered in the output stage, or in the skid entry while the output stalls
// throughput: one byte per cycle while in_stall is low, state updates in one registered pass
// reset: arst_n clears parser state and the output and skid valid flags, size limit to 65536
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        payload_valid,
	output logic        header_done,
	output logic [3:0]  opcode,
	output logic [3:0]  message_type,
	output logic        fin_flag,
	output logic [31:0] payload_length,
	output logic        frame_last,
	output logic        error_flag,
	output logic [3:0]  error_code
);

	`include "websocket_frame_deframer_unit_assert.svh"

	wsdf_pkg::res_t res;
	wsdf_pkg::res_t out_res_q;
	wsdf_pkg::res_t skid_res_q;
	logic           out_valid_q;
	logic           skid_valid_q;
	logic           accept;
	logic           take;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	wsdf_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.restart        (restart),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.res            (res)
	);

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (!out_valid_q || take)) begin
			out_res_q <= res;
		end else if (!accept && take && skid_valid_q) begin
			out_res_q <= skid_res_q;
		end
		if (accept && out_valid_q && !take) begin
			skid_res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_res_q.out_byte;
	assign payload_valid  = out_res_q.payload_valid;
	assign header_done    = out_res_q.header_done;
	assign opcode         = out_res_q.opcode;
	assign message_type   = out_res_q.message_type;
	assign fin_flag       = out_res_q.fin_flag;
	assign payload_length = out_res_q.payload_length;
	assign frame_last     = out_res_q.frame_last;
	assign error_flag     = out_res_q.error_flag;
	assign error_code     = out_res_q.error_code;

	`WSDF_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`WSDF_ASSERT_NEXT(a_empty_fill, clk, arst_n, accept && !out_valid_q, out_valid_q && !skid_valid_q)

endmodule
